### hdl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Types, constants and the CRC-16/MODBUS byte update for the serial frame
// parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int unsigned MaxPayload = 64;
  localparam int unsigned BufDepth   = 64;
  localparam int unsigned BufAw      = 6;
  localparam int unsigned LenW       = 7;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [3:0] {
    PH_SOF0,
    PH_SOF1,
    PH_VER,
    PH_TYPE,
    PH_SEQ,
    PH_LEN,
    PH_DATA,
    PH_CRCLO,
    PH_CRCHI,
    PH_EMIT_RD,
    PH_EMIT_OUT
  } phase_e;

  typedef enum logic [1:0] {
    CAUSE_NONE,
    CAUSE_VERSION,
    CAUSE_LENGTH,
    CAUSE_CRC
  } cause_e;

  typedef enum logic {
    KIND_DATA,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    SEL_ERROR,
    SEL_EMPTY,
    SEL_DATA
  } res_sel_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_FIRST,
    CFG_START_SECOND,
    CFG_VERSION
  } cfg_idx_e;

  typedef struct packed {
    logic     crc_init;
    logic     crc_feed;
    logic     hold_type;
    logic     hold_seq;
    logic     hold_len;
    logic     hold_crc_lo;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     buf_wr;
    logic     buf_rd;
    logic     out_load;
    res_sel_e out_sel;
    cause_e   cause;
  } sfp_cmd_t;

  typedef struct packed {
    logic is_first;
    logic is_second;
    logic ver_ok;
    logic len_over;
    logic len_zero;
    logic data_done;
    logic crc_ok;
    logic held_len_zero;
    logic emit_last;
    logic can_load;
  } sfp_status_t;

  typedef struct packed {
    kind_e            result_kind;
    cause_e           error_cause;
    logic [7:0]       frame_type;
    logic [7:0]       frame_sequence;
    logic [LenW-1:0]  frame_len;
    logic [BufAw-1:0] byte_index;
    logic [7:0]       payload_byte;
    logic             byte_valid;
    logic             last;
  } sfp_result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/sfp_if.sv
// ----------------------------------------------------------------------------
// sfp_rx_if / sfp_res_if
// Valid/ready channels for received bytes and parser results.
// ----------------------------------------------------------------------------
interface sfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_res_if import sfp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [1:0]       error_cause;
  logic [7:0]       frame_type;
  logic [7:0]       frame_sequence;
  logic [LenW-1:0]  frame_len;
  logic [BufAw-1:0] byte_index;
  logic [7:0]       payload_byte;
  logic             byte_valid;
  logic             last;

  modport source (output valid, output result_kind, output error_cause, output frame_type,
                  output frame_sequence, output frame_len, output byte_index,
                  output payload_byte, output byte_valid, output last, input ready);
  modport sink   (input valid, input result_kind, input error_cause, input frame_type,
                  input frame_sequence, input frame_len, input byte_index,
                  input payload_byte, input byte_valid, input last, output ready);
endinterface

### hdl/sfp_ram.sv
// ----------------------------------------------------------------------------
// sfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sfp_ctrl.sv
// ----------------------------------------------------------------------------
// sfp_ctrl
// Frame parse and result emission state machine.
// ----------------------------------------------------------------------------
module sfp_ctrl import sfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sfp_status_t st_i,
  output sfp_cmd_t    cmd_o
);

  phase_e state_q, state_d;
  logic   fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_SOF0;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q != PH_EMIT_RD) && (state_q != PH_EMIT_OUT) && st_i.can_load;
    fire       = in_valid_i && in_ready_o;
    case (state_q)
      PH_SOF1: begin
        if (fire) begin
          if (st_i.is_second) begin
            state_d        = PH_VER;
            cmd_o.crc_init = 1'b1;
          end else if (!st_i.is_first) begin
            state_d = PH_SOF0;
          end
        end
      end
      PH_VER: begin
        if (fire) begin
          if (!st_i.ver_ok) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_ERROR;
            cmd_o.cause    = CAUSE_VERSION;
            state_d        = PH_SOF0;
          end else begin
            cmd_o.crc_feed = 1'b1;
            state_d        = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        if (fire) begin
          cmd_o.hold_type = 1'b1;
          cmd_o.crc_feed  = 1'b1;
          state_d         = PH_SEQ;
        end
      end
      PH_SEQ: begin
        if (fire) begin
          cmd_o.hold_seq = 1'b1;
          cmd_o.crc_feed = 1'b1;
          state_d        = PH_LEN;
        end
      end
      PH_LEN: begin
        if (fire) begin
          cmd_o.cnt_clr = 1'b1;
          if (st_i.len_over) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_ERROR;
            cmd_o.cause    = CAUSE_LENGTH;
            state_d        = PH_SOF0;
          end else begin
            cmd_o.hold_len = 1'b1;
            cmd_o.crc_feed = 1'b1;
            state_d        = st_i.len_zero ? PH_CRCLO : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (fire) begin
          cmd_o.buf_wr   = 1'b1;
          cmd_o.crc_feed = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          if (st_i.data_done) begin
            state_d = PH_CRCLO;
          end
        end
      end
      PH_CRCLO: begin
        if (fire) begin
          cmd_o.hold_crc_lo = 1'b1;
          state_d           = PH_CRCHI;
        end
      end
      PH_CRCHI: begin
        if (fire) begin
          if (!st_i.crc_ok) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_ERROR;
            cmd_o.cause    = CAUSE_CRC;
            state_d        = PH_SOF0;
          end else if (st_i.held_len_zero) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_EMPTY;
            state_d        = PH_SOF0;
          end else begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = PH_EMIT_RD;
          end
        end
      end
      PH_EMIT_RD: begin
        cmd_o.buf_rd = 1'b1;
        state_d      = PH_EMIT_OUT;
      end
      PH_EMIT_OUT: begin
        if (st_i.can_load) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_DATA;
          cmd_o.cnt_inc  = 1'b1;
          state_d        = st_i.emit_last ? PH_SOF0 : PH_EMIT_RD;
        end
      end
      default: begin
        if (fire) begin
          state_d = st_i.is_first ? PH_SOF1 : PH_SOF0;
        end
      end
    endcase
  end

endmodule

### hdl/sfp_datapath.sv
// ----------------------------------------------------------------------------
// sfp_datapath
// Config registers, header holding, running CRC, payload buffer and the
// output result register.
// ----------------------------------------------------------------------------
module sfp_datapath import sfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic [7:0]         rx_byte_i,
  input  sfp_cmd_t           cmd_i,
  output sfp_status_t        st_o,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output sfp_result_t        res_o
);

  logic [7:0]      start_first_q, start_second_q, version_q;
  logic [7:0]      type_q, seq_q, crc_lo_q;
  logic [LenW-1:0] len_q, cnt_q;
  logic [15:0]     crc_q;
  logic            res_valid_q;
  sfp_result_t     res_q, res_d;
  logic [7:0]      buf_rdata;
  logic [LenW:0]   cnt_next;

  assign cnt_next = {1'b0, cnt_q} + {{LenW{1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_first_q  <= 8'hAA;
      start_second_q <= 8'h55;
      version_q      <= 8'h01;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_FIRST:  start_first_q  <= cfg_wdata_i;
        CFG_START_SECOND: start_second_q <= cfg_wdata_i;
        CFG_VERSION:      version_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q   <= '0;
      seq_q    <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      crc_lo_q <= '0;
      crc_q    <= CrcInit;
    end else begin
      if (cmd_i.hold_type)   type_q   <= rx_byte_i;
      if (cmd_i.hold_seq)    seq_q    <= rx_byte_i;
      if (cmd_i.hold_len)    len_q    <= rx_byte_i[LenW-1:0];
      if (cmd_i.hold_crc_lo) crc_lo_q <= rx_byte_i;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_next[LenW-1:0];
      end
      if (cmd_i.crc_init) begin
        crc_q <= CrcInit;
      end else if (cmd_i.crc_feed) begin
        crc_q <= crc_feed(crc_q, rx_byte_i);
      end
    end
  end

  sfp_ram #(
    .Width (8),
    .Depth (BufDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.buf_wr),
    .waddr_i (cnt_q[BufAw-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.buf_rd),
    .raddr_i (cnt_q[BufAw-1:0]),
    .rdata_o (buf_rdata)
  );

  always_comb begin
    res_d = '0;
    case (cmd_i.out_sel)
      SEL_ERROR: begin
        res_d.result_kind = KIND_ERROR;
        res_d.error_cause = cmd_i.cause;
        res_d.last        = 1'b1;
      end
      SEL_EMPTY: begin
        res_d.result_kind    = KIND_DATA;
        res_d.frame_type     = type_q;
        res_d.frame_sequence = seq_q;
        res_d.last           = 1'b1;
      end
      SEL_DATA: begin
        res_d.result_kind    = KIND_DATA;
        res_d.frame_type     = type_q;
        res_d.frame_sequence = seq_q;
        res_d.frame_len      = len_q;
        res_d.byte_index     = cnt_q[BufAw-1:0];
        res_d.payload_byte   = buf_rdata;
        res_d.byte_valid     = 1'b1;
        res_d.last           = st_o.emit_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    st_o.is_first      = (rx_byte_i == start_first_q);
    st_o.is_second     = (rx_byte_i == start_second_q);
    st_o.ver_ok        = (rx_byte_i == version_q);
    st_o.len_over      = ({1'b0, rx_byte_i} > 9'(MaxPayload));
    st_o.len_zero      = (rx_byte_i == 8'h00);
    st_o.data_done     = (cnt_next >= {1'b0, len_q});
    st_o.crc_ok        = ({rx_byte_i, crc_lo_q} == crc_q);
    st_o.held_len_zero = (len_q == '0);
    st_o.emit_last     = (cnt_next == {1'b0, len_q});
    st_o.can_load      = !res_valid_q || res_ready_i;
  end

endmodule

### hdl/serial_frame_parser_crc16_core.sv
// ----------------------------------------------------------------------------
// serial_frame_parser_crc16_core
// Byte-stream frame parser with CRC-16/MODBUS check and payload replay.
// ----------------------------------------------------------------------------
// Received bytes are taken when the result register is free; a
// byte may produce an error result, so rx ready drops while an untaken result
// is held. After a good CRC the buffered payload is replayed one byte at a
// time (buffer RAM registered read, then the result register), with rx ready
// low for the whole run; an empty payload or an error gives one result at
// once. A frame of n payload bytes is n + 8 bytes long, and its replay
// follows as an unpipelined read-then-load sequence.
module serial_frame_parser_crc16_core import sfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  sfp_rx_if.sink             rx_i,
  sfp_res_if.source          res_o
);

  sfp_cmd_t    cmd;
  sfp_status_t st;
  sfp_result_t res;
  logic        res_valid;

  sfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  sfp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (rx_i.rx_byte),
    .cmd_i       (cmd),
    .st_o        (st),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign res_o.valid          = res_valid;
  assign res_o.result_kind    = res.result_kind;
  assign res_o.error_cause    = res.error_cause;
  assign res_o.frame_type     = res.frame_type;
  assign res_o.frame_sequence = res.frame_sequence;
  assign res_o.frame_len      = res.frame_len;
  assign res_o.byte_index     = res.byte_index;
  assign res_o.payload_byte   = res.payload_byte;
  assign res_o.byte_valid     = res.byte_valid;
  assign res_o.last           = res.last;

endmodule
